FILE: design/abd_pkg.sv
// ----------------------------------------------------------------------------
// abd_pkg: shared types and constants of the arcade bus decoder
// Beat layouts of both channels, the command codes and the address map.
// ----------------------------------------------------------------------------
package abd_pkg;

  localparam int unsigned BankBytesDefault = 4096;
  localparam int unsigned BankCountDefault = 2;

  // The fourth code is not a command and leaves every register alone.
  typedef enum logic [1:0] {
    CMD_READ   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_UNUSED = 2'd3
  } abd_cmd_e;

  // Address map boundaries.
  localparam logic [15:0] ROM_END       = 16'h4000;
  localparam logic [15:0] VRAM_BASE     = 16'h4000;
  localparam logic [15:0] VRAM_END      = 16'h5000;
  localparam logic [15:0] VIDEO_BASE    = 16'h5000;
  localparam logic [15:0] VIDEO_END     = 16'h5400;
  localparam logic [15:0] SCROLL_BASE   = 16'h5800;
  localparam logic [15:0] SCROLL_END    = 16'h5C00;
  localparam logic [15:0] SOUND_A_BASE  = 16'h6000;
  localparam logic [15:0] SOUND_A_END   = 16'h6400;
  localparam logic [15:0] SOUND_B_BASE  = 16'h6800;
  localparam logic [15:0] SOUND_B_END   = 16'h6C00;
  localparam logic [15:0] BUTTONS_BASE  = 16'h7000;
  localparam logic [15:0] BUTTONS_END   = 16'h7800;
  localparam logic [15:0] DIP_BASE      = 16'h7800;
  localparam logic [15:0] DIP_END       = 16'h7C00;

  localparam logic [6:0] DIP_RESET    = 7'd64;
  localparam logic [7:0] BUTTON_RESET = 8'hFF;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic [7:0]  buttons;
  } abd_in_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       rom_hit;
    logic       sound_a_strobe;
    logic       sound_b_strobe;
    logic [7:0] sound_value;
    logic       frame_done;
    logic [7:0] video_ctrl;
    logic [7:0] scroll_x;
  } abd_out_t;

endpackage

FILE: design/abd_vram.sv
// ----------------------------------------------------------------------------
// abd_vram: banked video RAM with a clearing sweep after reset
// One port, read data registered; zeroes every entry once after reset.
// ----------------------------------------------------------------------------
module abd_vram #(
  parameter int unsigned Depth = 8192,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [7:0]       wdata_i,
  output logic [7:0]       rdata_o,
  output logic             busy_o
);

  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);

  logic [7:0]       mem [Depth];
  logic [7:0]       rdata_q;
  logic             clr_q, clr_d;
  logic [AddrW-1:0] clr_cnt_q, clr_cnt_d;

  always_comb begin
    clr_d     = clr_q;
    clr_cnt_d = clr_cnt_q;
    if (clr_q) begin
      clr_cnt_d = clr_cnt_q + AddrW'(1);
      if (clr_cnt_q == LastAddr) begin
        clr_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else begin
      clr_q     <= clr_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem[clr_cnt_q] <= 8'h00;
    end else if (wr_en_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = clr_q;

endmodule

FILE: design/arcade_bus_decoder_vblank_unit.sv
// ----------------------------------------------------------------------------
// arcade_bus_decoder_vblank_unit: CPU bus decoder of a tile arcade board
// Decodes reads, writes and frame ticks into video RAM and board registers.
// ----------------------------------------------------------------------------
//   channel  | direction | handshake              | beat
//   ---------+-----------+------------------------+-----------
//   in       | in        | in_valid_i / in_stall_o | abd_in_t
//   out      | out       | out_valid_o / out_stall_i | abd_out_t
//   cfg      | in        | cfg_we_i                | dip bits
//
// One beat is accepted per cycle while in_stall_o is low; its result passes
// through stage A, which waits on the synchronous video RAM read, and then the output register.
// After reset the video RAM sweep zeroes one byte a cycle, all BANK_BYTES *
// BANK_COUNT bytes (8192 by default), and in_stall_o stays high until it ends.
// A stalled output holds one result while one more beat waits behind it.
// ----------------------------------------------------------------------------
module arcade_bus_decoder_vblank_unit #(
  parameter int unsigned BANK_BYTES = abd_pkg::BankBytesDefault,
  parameter int unsigned BANK_COUNT = abd_pkg::BankCountDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  abd_pkg::abd_in_t  in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output abd_pkg::abd_out_t out_o,
  input  logic              cfg_we_i,
  input  logic [6:0]        cfg_wdata_i
);

  import abd_pkg::*;

  localparam int unsigned Depth = BANK_BYTES * BANK_COUNT;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned OffW  = $clog2(BANK_BYTES);
  localparam int unsigned BankW = AddrW - OffW;

  // Board registers.
  logic [7:0] video_q, video_d;
  logic [7:0] scroll_q, scroll_d;
  logic [7:0] latch_q, latch_d;
  logic       in_vb_q, in_vb_d;
  logic       vblank_q, vblank_d;
  logic [6:0] dip_q;

  // Pipeline: stage A waits on the RAM read, stage B is the output register.
  logic       a_valid_q, b_valid_q;
  logic       a_mem_q, a_mem_d;
  abd_out_t   a_q, a_d;
  abd_out_t   b_q;
  logic       accept, a_move;

  logic             vram_busy;
  logic [7:0]       vram_rdata;
  logic             vram_rd, vram_wr;
  logic [AddrW-1:0] vram_addr;
  logic [15:0]      vram_off;

  assign a_move     = a_valid_q && (!b_valid_q || !out_stall_i);
  assign in_stall_o = vram_busy || (a_valid_q && !a_move);
  assign accept     = in_valid_i && !in_stall_o;

  assign vram_off  = in_i.addr - VRAM_BASE;
  assign vram_addr = {video_q[BankW-1:0], vram_off[OffW-1:0]};

  always_comb begin
    video_d  = video_q;
    scroll_d = scroll_q;
    latch_d  = latch_q;
    in_vb_d  = in_vb_q;
    vblank_d = vblank_q;
    a_mem_d  = 1'b0;
    vram_rd  = 1'b0;
    vram_wr  = 1'b0;
    a_d      = '0;

    case (in_i.cmd)
      CMD_READ: begin
        if (in_i.addr < ROM_END) begin
          a_d.rom_hit = 1'b1;
        end else if (in_i.addr < VRAM_END) begin
          a_mem_d = 1'b1;
          vram_rd = accept;
        end else if (in_i.addr inside {[DIP_BASE:DIP_END - 16'd1]}) begin
          a_d.rdata = {vblank_q, dip_q};
        end else if (in_i.addr inside {[BUTTONS_BASE:BUTTONS_END - 16'd1]}) begin
          a_d.rdata = latch_q;
        end
      end
      CMD_WRITE: begin
        if (in_i.addr inside {[VRAM_BASE:VRAM_END - 16'd1]}) begin
          vram_wr = accept;
        end else if (in_i.addr inside {[VIDEO_BASE:VIDEO_END - 16'd1]}) begin
          video_d = in_i.wdata;
        end else if (in_i.addr inside {[SCROLL_BASE:SCROLL_END - 16'd1]}) begin
          scroll_d = in_i.wdata;
        end else if (in_i.addr inside {[SOUND_A_BASE:SOUND_A_END - 16'd1]}) begin
          a_d.sound_a_strobe = 1'b1;
          a_d.sound_value    = in_i.wdata;
        end else if (in_i.addr inside {[SOUND_B_BASE:SOUND_B_END - 16'd1]}) begin
          a_d.sound_b_strobe = 1'b1;
          a_d.sound_value    = in_i.wdata;
        end
      end
      CMD_TICK: begin
        // Two-phase toggle: enter vblank, then leave it and latch buttons.
        in_vb_d  = !in_vb_q;
        vblank_d = in_vb_q;
        if (in_vb_q) begin
          latch_d         = in_i.buttons;
          a_d.frame_done  = 1'b1;
        end
      end
      default: ;
    endcase

    a_d.video_ctrl = video_d;
    a_d.scroll_x   = scroll_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      video_q   <= '0;
      scroll_q  <= '0;
      latch_q   <= BUTTON_RESET;
      in_vb_q   <= 1'b0;
      vblank_q  <= 1'b1;
      dip_q     <= DIP_RESET;
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        video_q  <= video_d;
        scroll_q <= scroll_d;
        latch_q  <= latch_d;
        in_vb_q  <= in_vb_d;
        vblank_q <= vblank_d;
      end
      if (cfg_we_i) begin
        dip_q <= cfg_wdata_i;
      end
      if (accept) begin
        a_valid_q <= 1'b1;
      end else if (a_move) begin
        a_valid_q <= 1'b0;
      end
      if (a_move) begin
        b_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        b_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_q     <= a_d;
      a_mem_q <= a_mem_d;
    end
    if (a_move) begin
      b_q <= a_q;
      if (a_mem_q) begin
        b_q.rdata <= vram_rdata;
      end
    end
  end

  abd_vram #(
    .Depth (Depth)
  ) u_vram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_en_i (vram_rd),
    .wr_en_i (vram_wr),
    .addr_i  (vram_addr),
    .wdata_i (in_i.wdata),
    .rdata_o (vram_rdata),
    .busy_o  (vram_busy)
  );

  assign out_valid_o = b_valid_q;
  assign out_o       = b_q;

endmodule

FILE: verif/arcade_bus_decoder_vblank_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// arcade_bus_decoder_vblank_unit_test: bus decoder self-checking bench
// Feeds CPU reads, writes and frame ticks through the input channel with
// random idle and stall bursts. The expected result of every accepted beat
// is predicted here and compared field by field with the output channel.
// ----------------------------------------------------------------------------
module arcade_bus_decoder_vblank_unit_test;

  import abd_pkg::*;

  logic     clk_i;
  logic     rst_ni      = 1'b0;
  logic     in_valid    = 1'b0;
  logic     in_stall_o;
  abd_in_t  in_beat     = '0;
  logic     out_valid_o;
  logic     out_stall   = 1'b0;
  abd_out_t out_o;
  logic     cfg_we      = 1'b0;
  logic [6:0] cfg_wdata = '0;

  arcade_bus_decoder_vblank_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_i        (in_beat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_o       (out_o),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  // Bus commands waiting to be driven and results still owed by the block.
  abd_in_t  bus_cmd_q[$];
  abd_out_t bus_result_q[$];

  int unsigned mismatches = 0;
  bit          quiet      = 1'b0;
  int unsigned in_gap     = 0;
  int unsigned stall_left = 0;

  // Board state as the decoder should hold it.
  logic [7:0] vram_m [0:8191];
  logic [7:0] vid_ctl_m;
  logic [7:0] scroll_m;
  logic [7:0] buttons_m;
  logic       in_vblank_m;
  logic       vblank_m;
  logic [6:0] dip_m;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  function automatic abd_out_t predict_bus_beat(abd_in_t b);
    abd_out_t    r;
    logic [12:0] idx;
    r   = '0;
    idx = {vid_ctl_m[0], b.addr[11:0]};
    case (b.cmd)
      CMD_READ: begin
        if (b.addr < ROM_END) r.rom_hit = 1'b1;
        else if (b.addr < VRAM_END) r.rdata = vram_m[idx];
        else if (b.addr >= DIP_BASE && b.addr < DIP_END) r.rdata = {vblank_m, dip_m};
        else if (b.addr >= BUTTONS_BASE && b.addr < BUTTONS_END) r.rdata = buttons_m;
      end
      CMD_WRITE: begin
        if (b.addr >= VRAM_BASE && b.addr < VRAM_END) begin
          vram_m[idx] = b.wdata;
        end else if (b.addr >= VIDEO_BASE && b.addr < VIDEO_END) begin
          vid_ctl_m = b.wdata;
        end else if (b.addr >= SCROLL_BASE && b.addr < SCROLL_END) begin
          scroll_m = b.wdata;
        end else if (b.addr >= SOUND_A_BASE && b.addr < SOUND_A_END) begin
          r.sound_a_strobe = 1'b1;
          r.sound_value    = b.wdata;
        end else if (b.addr >= SOUND_B_BASE && b.addr < SOUND_B_END) begin
          r.sound_b_strobe = 1'b1;
          r.sound_value    = b.wdata;
        end
      end
      CMD_TICK: begin
        if (!in_vblank_m) begin
          vblank_m    = 1'b0;
          in_vblank_m = 1'b1;
        end else begin
          vblank_m     = 1'b1;
          in_vblank_m  = 1'b0;
          buttons_m    = b.buttons;
          r.frame_done = 1'b1;
        end
      end
      default: ;
    endcase
    r.video_ctrl = vid_ctl_m;
    r.scroll_x   = scroll_m;
    return r;
  endfunction

  function automatic abd_in_t make_beat(logic [1:0] cmd, logic [15:0] addr,
                                        logic [7:0] wdata, logic [7:0] buttons);
    abd_in_t b;
    b.cmd     = cmd;
    b.addr    = addr;
    b.wdata   = wdata;
    b.buttons = buttons;
    return b;
  endfunction

  // Addresses are mostly aimed at mapped regions; a small window of video RAM
  // is favored so that reads come back with bytes written earlier.
  function automatic logic [15:0] pick_addr();
    logic [15:0] a;
    a = 16'($urandom);
    case ($urandom_range(0, 11))
      0:       a = {2'b00, a[13:0]};
      1, 2:    a = {4'h4, 7'd0, a[4:0]};
      3, 4:    a = {4'h4, a[11:0]};
      5:       a = VIDEO_BASE | {6'd0, a[9:0]};
      6:       a = SCROLL_BASE | {6'd0, a[9:0]};
      7:       a = SOUND_A_BASE | {6'd0, a[9:0]};
      8:       a = SOUND_B_BASE | {6'd0, a[9:0]};
      9:       a = BUTTONS_BASE | {5'd0, a[10:0]};
      10:      a = DIP_BASE | {6'd0, a[9:0]};
      default: ;
    endcase
    return a;
  endfunction

  function automatic logic [1:0] pick_cmd();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 8) return CMD_READ;
    if (r < 15) return CMD_WRITE;
    if (r < 19) return CMD_TICK;
    return CMD_UNUSED;
  endfunction

  // Sampled at the falling edge so that a beat the driver has just offered
  // is already visible on in_valid.
  task automatic wait_drained();
    while (bus_cmd_q.size() != 0 || in_valid || bus_result_q.size() != 0)
      @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_dip(input logic [6:0] value);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    dip_m = value;
  endtask

  // Driver: records the expectation of each accepted beat, then offers the
  // next one unless an idle burst is running.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall_o) begin
        bus_result_q.push_back(predict_bus_beat(in_beat));
        if (!quiet && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 9);
      end
      if (!in_valid || !in_stall_o) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (bus_cmd_q.size() != 0) begin
          in_beat  <= bus_cmd_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result beat and stalls the output in bursts.
  always @(posedge clk_i) begin
    abd_out_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall) begin
        if (bus_result_q.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing expected: %h", out_o));
        end else begin
          want = bus_result_q.pop_front();
          check_field("rdata", out_o.rdata, want.rdata);
          check_field("rom_hit", 8'(out_o.rom_hit), 8'(want.rom_hit));
          check_field("sound_a_strobe", 8'(out_o.sound_a_strobe),
                      8'(want.sound_a_strobe));
          check_field("sound_b_strobe", 8'(out_o.sound_b_strobe),
                      8'(want.sound_b_strobe));
          check_field("sound_value", out_o.sound_value, want.sound_value);
          check_field("frame_done", 8'(out_o.frame_done), 8'(want.frame_done));
          check_field("video_ctrl", out_o.video_ctrl, want.video_ctrl);
          check_field("scroll_x", out_o.scroll_x, want.scroll_x);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 9) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    logic [6:0] dip_plan [3];
    for (int i = 0; i < 8192; i++) vram_m[i] = 8'h00;
    vid_ctl_m   = 8'h00;
    scroll_m    = 8'h00;
    buttons_m   = BUTTON_RESET;
    in_vblank_m = 1'b0;
    vblank_m    = 1'b1;
    dip_m       = DIP_RESET;
    dip_plan[0] = 7'h7F;
    dip_plan[1] = 7'h00;
    dip_plan[2] = 7'($urandom);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: map edges, both banks, all registers, both tick phases,
    // unmapped addresses and the unused command.
    bus_cmd_q.push_back(make_beat(CMD_READ,  16'h0000, 8'h00, 8'h00));
    bus_cmd_q.push_back(make_beat(CMD_READ,  16'h3FFF, 8'hFF, 8'hFF));
    bus_cmd_q.push_back(make_beat(CMD_READ,  16'h4FFF, 8'h00, 8'h00));
    bus_cmd_q.push_back(make_beat(CMD_WRITE, 16'h4000, 8'hFF, 8'h00));
    bus_cmd_q.push_back(make_beat(CMD_WRITE, 16'h4FFF, 8'h81, 8'h00));
    bus_cmd_q.push_back(make_beat(CMD_WRITE, 16'h5000, 8'h01, 8'h00));
    bus_cmd_q.push_back(make_beat(CMD_READ,  16'h4000, 8'h00, 8'h00));
    bus_cmd_q.push_back(make_beat(CMD_WRITE, 16'h4000, 8'hA5, 8'h00));
    bus_cmd_q.push_back(make_beat(CMD_WRITE, 16'h53FF, 8'hFE, 8'h00));
    bus_cmd_q.push_back(make_beat(CMD_READ,  16'h4000, 8'h00, 8'h00));
    bus_cmd_q.push_back(make_beat(CMD_READ,  16'h4FFF, 8'h00, 8'h00));
    bus_cmd_q.push_back(make_beat(CMD_WRITE, 16'h5800, 8'hFF, 8'h00));
    bus_cmd_q.push_back(make_beat(CMD_WRITE, 16'h5BFF, 8'h00, 8'h00));
    bus_cmd_q.push_back(make_beat(CMD_WRITE, 16'h6000, 8'h5A, 8'h00));
    bus_cmd_q.push_back(make_beat(CMD_WRITE, 16'h6BFF, 8'hFF, 8'h00));
    bus_cmd_q.push_back(make_beat(CMD_READ,  16'h7800, 8'h00, 8'h00));
    bus_cmd_q.push_back(make_beat(CMD_TICK,  16'hFFFF, 8'hFF, 8'hFF));
    bus_cmd_q.push_back(make_beat(CMD_READ,  16'h7BFF, 8'h00, 8'h00));
    bus_cmd_q.push_back(make_beat(CMD_TICK,  16'h0000, 8'h00, 8'h00));
    bus_cmd_q.push_back(make_beat(CMD_READ,  16'h7000, 8'h00, 8'h00));
    bus_cmd_q.push_back(make_beat(CMD_READ,  16'hFFFF, 8'h00, 8'h00));
    bus_cmd_q.push_back(make_beat(CMD_WRITE, 16'hFFFF, 8'h77, 8'h00));
    bus_cmd_q.push_back(make_beat(CMD_WRITE, 16'h5400, 8'h33, 8'h00));
    bus_cmd_q.push_back(make_beat(CMD_UNUSED, 16'h6000, 8'hFF, 8'hFF));
    bus_cmd_q.push_back(make_beat(CMD_READ,  16'h77FF, 8'h00, 8'h00));
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      write_dip(dip_plan[ph]);
      // The last phase runs without any idling on either side.
      if (ph == 2) quiet = 1'b1;
      for (int n = 0; n < 145; n++)
        bus_cmd_q.push_back(make_beat(pick_cmd(), pick_addr(), 8'($urandom),
                                      8'($urandom)));
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && bus_result_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/abd_pkg.sv
design/abd_vram.sv
design/arcade_bus_decoder_vblank_unit.sv
verif/arcade_bus_decoder_vblank_unit_test.sv
